FILE: rtl/core/pcrl_pkg.sv
// Package for the packed grid-map decoder: field widths, cell codes,
// command opcodes and the command word passed from the parser to the expander.
// No dependencies.
`default_nettype none

package pcrl_pkg;

  // Widths of the result fields.
  localparam int COL_W  = 6;
  localparam int ROW_W  = 5;
  localparam int CELL_W = 3;

  // Run count width (a run holds up to nine cells).
  localparam int CNT_W  = 4;

  // Field that carries the grid width to the expander (holds up to 127).
  localparam int GWF_W  = 7;

  // Command queue depth and pointer width.
  localparam int QDEPTH = 4;
  localparam int QA_W   = 2;

  // Command opcodes.
  localparam logic [1:0] OP_HDR = 2'd0;
  localparam logic [1:0] OP_RUN = 2'd1;
  localparam logic [1:0] OP_POS = 2'd2;

  // Cell codes on the result channel.
  localparam logic [CELL_W-1:0] CELL_EMPTY  = 3'd0;
  localparam logic [CELL_W-1:0] CELL_WALL   = 3'd1;
  localparam logic [CELL_W-1:0] CELL_BOX    = 3'd2;
  localparam logic [CELL_W-1:0] CELL_TARGET = 3'd3;
  localparam logic [CELL_W-1:0] CELL_BOXT   = 3'd4;

  // Command word: a header (new grid width), a run of cells, or the player position.
  typedef struct packed {
    logic [1:0]        op;
    logic [CELL_W-1:0] cell_code;
    logic [CNT_W-1:0]  count;
    logic              last;
    logic [GWF_W-1:0]  gw;
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
  } cmd_t;

endpackage

`default_nettype wire

FILE: rtl/core/pcrl_in_if.sv
// Input channel of the map decoder: one record byte per transaction.
// No dependencies.
`default_nettype none

interface pcrl_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/pcrl_out_if.sv
// Result channel of the map decoder: one cell or player position per transaction.
// Depends on pcrl_pkg for the field widths.
`default_nettype none

interface pcrl_out_if;
  logic                         valid;
  logic                         ready;
  logic                         kind;
  logic [pcrl_pkg::CELL_W-1:0]  cell_res;
  logic [pcrl_pkg::COL_W-1:0]   col;
  logic [pcrl_pkg::ROW_W-1:0]   row;
  logic                         map_done;
  logic                         last;

  modport source (output valid, output kind, output cell_res, output col, output row,
                  output map_done, output last, input ready);
  modport sink   (input valid, input kind, input cell_res, input col, input row,
                  input map_done, input last, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/pcrl_queue.sv
// Short command queue between the byte parser and the cell expander.
// Depends on pcrl_pkg for the command word and the depth.
`default_nettype none

module pcrl_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire pcrl_pkg::cmd_t push_data,
  output logic                full,
  input  wire logic           pop,
  output pcrl_pkg::cmd_t      pop_data,
  output logic                empty
);

  pcrl_pkg::cmd_t              mem_r [pcrl_pkg::QDEPTH];
  logic [pcrl_pkg::QA_W-1:0]   wr_r;
  logic [pcrl_pkg::QA_W-1:0]   rd_r;
  logic [pcrl_pkg::QA_W:0]     cnt_r;
  logic [pcrl_pkg::QA_W:0]     cnt_nxt;

  // Status flags from the fill count.
  assign full     = (cnt_r == (pcrl_pkg::QA_W + 1)'(pcrl_pkg::QDEPTH));
  assign empty    = (cnt_r == '0);
  assign pop_data = mem_r[rd_r];

  // Fill count follows pushes and pops.
  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  // Pointers and count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wr_r <= wr_r + 1'b1;
      end
      if (pop) begin
        rd_r <= rd_r + 1'b1;
      end
      cnt_r <= cnt_nxt;
    end
  end

  // Storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_data;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (!full || pop))
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty)
    else $error("queue pop while empty");

endmodule

`default_nettype wire

FILE: rtl/core/pcrl_front.sv
// Byte parser of the map decoder: takes header, cell and epilog bytes, walks the cell
// stream one bit per cycle while the queue has room, and queues header, run and position
// commands. Depends on pcrl_pkg and pcrl_in_if.
`default_nettype none

module pcrl_front #(
  parameter int MAX_COLS = 40,
  parameter int MAX_ROWS = 25
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  pcrl_in_if.sink        in_chan,
  input  wire logic      q_full,
  output logic           q_push,
  output pcrl_pkg::cmd_t q_data
);

  localparam int GW_W = $clog2(MAX_COLS + 1);
  localparam int GH_W = $clog2(MAX_ROWS + 1);
  localparam int RW   = GW_W + GH_W;
  localparam int CW   = (RW > pcrl_pkg::CNT_W) ? RW : pcrl_pkg::CNT_W;

  localparam logic [7:0] MAXC_B  = 8'(MAX_COLS);
  localparam logic [7:0] MAXR_B  = 8'(MAX_ROWS);
  localparam logic [7:0] LASTC_B = 8'(MAX_COLS - 1);
  localparam logic [7:0] LASTR_B = 8'(MAX_ROWS - 1);

  // Record phases.
  localparam logic [2:0] PH_WIDTH  = 3'd0;
  localparam logic [2:0] PH_HEIGHT = 3'd1;
  localparam logic [2:0] PH_CELLS  = 3'd2;
  localparam logic [2:0] PH_PCOL   = 3'd3;
  localparam logic [2:0] PH_PROW   = 3'd4;

  // Code tree nodes.
  localparam logic [2:0] ND_START = 3'd0;
  localparam logic [2:0] ND_D3    = 3'd1;
  localparam logic [2:0] ND_D2    = 3'd2;
  localparam logic [2:0] ND_D1    = 3'd3;
  localparam logic [2:0] ND_C0    = 3'd4;
  localparam logic [2:0] ND_C0X   = 3'd5;
  localparam logic [2:0] ND_C1X   = 3'd6;
  localparam logic [2:0] ND_C11X  = 3'd7;

  logic [2:0]                    phase_r, phase_nxt;
  logic                          walk_r, walk_nxt;
  logic                          flush_r, flush_nxt;
  logic [GW_W-1:0]               width_r, width_nxt;
  logic [RW-1:0]                 rem_r, rem_nxt;
  logic [pcrl_pkg::COL_W-1:0]    pcol_r, pcol_nxt;
  logic [7:0]                    sh_r, sh_nxt;
  logic [2:0]                    bcnt_r, bcnt_nxt;
  logic [2:0]                    node_r, node_nxt;
  logic [pcrl_pkg::CNT_W-1:0]    runl_r, runl_nxt;
  logic                          pend_v_r, pend_v_nxt;
  logic [pcrl_pkg::CELL_W-1:0]   pend_cell_r, pend_cell_nxt;
  logic [pcrl_pkg::CNT_W-1:0]    pend_cnt_r, pend_cnt_nxt;

  logic                          accept;
  logic [GW_W-1:0]               w_sat;
  logic [GH_W-1:0]               h_sat;
  logic [pcrl_pkg::COL_W-1:0]    pc_sat;
  logic [pcrl_pkg::ROW_W-1:0]    pr_sat;
  logic                          b;
  logic [2:0]                    node_step;
  logic [pcrl_pkg::CNT_W-1:0]    runl_step;
  logic                          run_done;
  logic [pcrl_pkg::CELL_W-1:0]   cell_v;
  logic [pcrl_pkg::CNT_W-1:0]    emit_cnt;
  logic [RW-1:0]                 rem_after;
  logic                          grid_done;

  // A byte is taken only between bit walks and with room for a command.
  assign in_chan.ready = !walk_r && !flush_r && !q_full;
  assign accept        = in_chan.valid && in_chan.ready;

  // Saturated header and epilog values.
  assign w_sat  = (in_chan.data_byte > MAXC_B)  ? GW_W'(MAX_COLS) : GW_W'(in_chan.data_byte);
  assign h_sat  = (in_chan.data_byte > MAXR_B)  ? GH_W'(MAX_ROWS) : GH_W'(in_chan.data_byte);
  assign pc_sat = (in_chan.data_byte > LASTC_B) ? pcrl_pkg::COL_W'(MAX_COLS - 1)
                                                : pcrl_pkg::COL_W'(in_chan.data_byte);
  assign pr_sat = (in_chan.data_byte > LASTR_B) ? pcrl_pkg::ROW_W'(MAX_ROWS - 1)
                                                : pcrl_pkg::ROW_W'(in_chan.data_byte);

  // One step of the code tree on the current stream bit.
  always_comb begin
    b         = sh_r[7];
    node_step = node_r;
    runl_step = runl_r;
    run_done  = 1'b0;
    cell_v    = pcrl_pkg::CELL_EMPTY;
    unique case (node_r)
      ND_START: begin
        runl_step = b ? pcrl_pkg::CNT_W'(2) : pcrl_pkg::CNT_W'(1);
        node_step = b ? ND_D3 : ND_C0;
      end
      ND_D3: begin
        runl_step = runl_r + (b ? pcrl_pkg::CNT_W'(4) : '0);
        node_step = ND_D2;
      end
      ND_D2: begin
        runl_step = runl_r + (b ? pcrl_pkg::CNT_W'(2) : '0);
        node_step = ND_D1;
      end
      ND_D1: begin
        runl_step = runl_r + (b ? pcrl_pkg::CNT_W'(1) : '0);
        node_step = ND_C0;
      end
      ND_C0: begin
        node_step = b ? ND_C1X : ND_C0X;
      end
      ND_C0X: begin
        run_done = 1'b1;
        cell_v   = b ? pcrl_pkg::CELL_WALL : pcrl_pkg::CELL_EMPTY;
      end
      ND_C1X: begin
        if (b) begin
          node_step = ND_C11X;
        end else begin
          run_done = 1'b1;
          cell_v   = pcrl_pkg::CELL_BOX;
        end
      end
      ND_C11X: begin
        run_done = 1'b1;
        cell_v   = b ? pcrl_pkg::CELL_BOXT : pcrl_pkg::CELL_TARGET;
      end
    endcase
    if (run_done) begin
      node_step = ND_START;
      runl_step = '0;
    end
  end

  // A finished run is clipped to the cells left in the grid.
  assign emit_cnt  = (CW'(rem_r) < CW'(runl_r)) ? pcrl_pkg::CNT_W'(rem_r) : runl_r;
  assign rem_after = rem_r - RW'(emit_cnt);
  assign grid_done = run_done && (rem_after == '0);

  // Phase control, bit walk and command pushes.
  always_comb begin
    phase_nxt     = phase_r;
    walk_nxt      = walk_r;
    flush_nxt     = flush_r;
    width_nxt     = width_r;
    rem_nxt       = rem_r;
    pcol_nxt      = pcol_r;
    sh_nxt        = sh_r;
    bcnt_nxt      = bcnt_r;
    node_nxt      = node_r;
    runl_nxt      = runl_r;
    pend_v_nxt    = pend_v_r;
    pend_cell_nxt = pend_cell_r;
    pend_cnt_nxt  = pend_cnt_r;
    q_push        = 1'b0;
    q_data        = '0;
    if (accept) begin
      unique case (phase_r)
        PH_WIDTH: begin
          width_nxt = w_sat;
          node_nxt  = ND_START;
          runl_nxt  = '0;
          phase_nxt = PH_HEIGHT;
        end
        PH_HEIGHT: begin
          rem_nxt   = RW'(width_r) * RW'(h_sat);
          node_nxt  = ND_START;
          runl_nxt  = '0;
          q_push    = 1'b1;
          q_data.op = pcrl_pkg::OP_HDR;
          q_data.gw = pcrl_pkg::GWF_W'(width_r);
          phase_nxt = (width_r == '0 || h_sat == '0) ? PH_PCOL : PH_CELLS;
        end
        PH_CELLS: begin
          sh_nxt   = in_chan.data_byte;
          bcnt_nxt = 3'd7;
          walk_nxt = 1'b1;
        end
        PH_PCOL: begin
          pcol_nxt  = pc_sat;
          phase_nxt = PH_PROW;
        end
        default: begin
          q_push      = 1'b1;
          q_data.op   = pcrl_pkg::OP_POS;
          q_data.col  = pcol_r;
          q_data.row  = pr_sat;
          q_data.last = 1'b1;
          phase_nxt   = PH_WIDTH;
        end
      endcase
    end else if (walk_r && !q_full) begin
      // The previous run is sent once a later run proves it is not the byte's last.
      sh_nxt   = {sh_r[6:0], 1'b0};
      bcnt_nxt = bcnt_r - 3'd1;
      node_nxt = node_step;
      runl_nxt = runl_step;
      if (run_done) begin
        rem_nxt = rem_after;
        if (pend_v_r) begin
          q_push           = 1'b1;
          q_data.op        = pcrl_pkg::OP_RUN;
          q_data.cell_code = pend_cell_r;
          q_data.count     = pend_cnt_r;
        end
        pend_v_nxt    = 1'b1;
        pend_cell_nxt = cell_v;
        pend_cnt_nxt  = emit_cnt;
      end
      if (grid_done) begin
        phase_nxt = PH_PCOL;
        node_nxt  = ND_START;
        runl_nxt  = '0;
      end
      if (grid_done || bcnt_r == 3'd0) begin
        walk_nxt  = 1'b0;
        flush_nxt = 1'b1;
      end
    end else if (flush_r) begin
      // The held run closes the byte's results.
      if (!pend_v_r) begin
        flush_nxt = 1'b0;
      end else if (!q_full) begin
        q_push           = 1'b1;
        q_data.op        = pcrl_pkg::OP_RUN;
        q_data.cell_code = pend_cell_r;
        q_data.count     = pend_cnt_r;
        q_data.last      = 1'b1;
        pend_v_nxt       = 1'b0;
        flush_nxt        = 1'b0;
      end
    end
  end

  // Control and record state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_WIDTH;
      walk_r   <= 1'b0;
      flush_r  <= 1'b0;
      width_r  <= '0;
      rem_r    <= '0;
      pcol_r   <= '0;
      node_r   <= ND_START;
      runl_r   <= '0;
      pend_v_r <= 1'b0;
    end else begin
      phase_r  <= phase_nxt;
      walk_r   <= walk_nxt;
      flush_r  <= flush_nxt;
      width_r  <= width_nxt;
      rem_r    <= rem_nxt;
      pcol_r   <= pcol_nxt;
      node_r   <= node_nxt;
      runl_r   <= runl_nxt;
      pend_v_r <= pend_v_nxt;
    end
  end

  // Byte shifter and held run.
  always_ff @(posedge clk) begin
    sh_r        <= sh_nxt;
    bcnt_r      <= bcnt_nxt;
    pend_cell_r <= pend_cell_nxt;
    pend_cnt_r  <= pend_cnt_nxt;
  end

  a_walk_in_cells: assert property (@(posedge clk) disable iff (!rst_n)
    walk_r |-> (phase_r == PH_CELLS && rem_r != '0))
    else $error("bit walk outside the cell phase or with no cells left");

  a_walk_flush_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(walk_r && flush_r))
    else $error("bit walk and flush at the same time");

endmodule

`default_nettype wire

FILE: rtl/core/pcrl_back.sv
// Cell expander of the map decoder: takes queued commands, expands runs into one cell
// result per cycle with column and row while the output is not stalled, and drives the
// output register. Depends on pcrl_pkg and pcrl_out_if.
`default_nettype none

module pcrl_back #(
  parameter int MAX_COLS = 40
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           q_empty,
  output logic                q_pop,
  input  wire pcrl_pkg::cmd_t q_data,
  pcrl_out_if.source          out_chan
);

  localparam int GW_W = $clog2(MAX_COLS + 1);

  logic                          ovalid_r, ovalid_nxt;
  logic                          okind_r, okind_nxt;
  logic [pcrl_pkg::CELL_W-1:0]   ocell_r, ocell_nxt;
  logic [pcrl_pkg::COL_W-1:0]    ocol_r, ocol_nxt;
  logic [pcrl_pkg::ROW_W-1:0]    orow_r, orow_nxt;
  logic                          odone_r, odone_nxt;
  logic                          olast_r, olast_nxt;
  logic                          active_r, active_nxt;
  logic [pcrl_pkg::CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [pcrl_pkg::CELL_W-1:0]   cell_r, cell_nxt;
  logic                          clast_r, clast_nxt;
  logic [GW_W-1:0]               width_r, width_nxt;
  logic [pcrl_pkg::COL_W-1:0]    col_r, col_nxt;
  logic [pcrl_pkg::ROW_W-1:0]    row_r, row_nxt;

  logic                          slot_free;
  logic [pcrl_pkg::COL_W:0]      col_inc;
  logic                          wrap;
  logic [pcrl_pkg::COL_W-1:0]    col_adv;
  logic [pcrl_pkg::ROW_W-1:0]    row_adv;

  assign out_chan.valid    = ovalid_r;
  assign out_chan.kind     = okind_r;
  assign out_chan.cell_res = ocell_r;
  assign out_chan.col      = ocol_r;
  assign out_chan.row      = orow_r;
  assign out_chan.map_done = odone_r;
  assign out_chan.last     = olast_r;

  assign slot_free = !ovalid_r || out_chan.ready;

  // Next grid position in row-major order.
  assign col_inc = {1'b0, col_r} + 1'b1;
  assign wrap    = (col_inc >= (pcrl_pkg::COL_W + 1)'(width_r));
  assign col_adv = wrap ? '0 : col_inc[pcrl_pkg::COL_W-1:0];
  assign row_adv = wrap ? row_r + 1'b1 : row_r;

  // Run expansion and command decode.
  always_comb begin
    ovalid_nxt = ovalid_r;
    okind_nxt  = okind_r;
    ocell_nxt  = ocell_r;
    ocol_nxt   = ocol_r;
    orow_nxt   = orow_r;
    odone_nxt  = odone_r;
    olast_nxt  = olast_r;
    active_nxt = active_r;
    cnt_nxt    = cnt_r;
    cell_nxt   = cell_r;
    clast_nxt  = clast_r;
    width_nxt  = width_r;
    col_nxt    = col_r;
    row_nxt    = row_r;
    q_pop      = 1'b0;
    if (slot_free) begin
      ovalid_nxt = 1'b0;
      if (active_r) begin
        ovalid_nxt = 1'b1;
        okind_nxt  = 1'b0;
        ocell_nxt  = cell_r;
        ocol_nxt   = col_r;
        orow_nxt   = row_r;
        odone_nxt  = 1'b0;
        olast_nxt  = clast_r && (cnt_r == pcrl_pkg::CNT_W'(1));
        cnt_nxt    = cnt_r - 1'b1;
        active_nxt = (cnt_r != pcrl_pkg::CNT_W'(1));
        col_nxt    = col_adv;
        row_nxt    = row_adv;
      end else if (!q_empty) begin
        q_pop = 1'b1;
        unique case (q_data.op)
          pcrl_pkg::OP_HDR: begin
            width_nxt = q_data.gw[GW_W-1:0];
            col_nxt   = '0;
            row_nxt   = '0;
          end
          pcrl_pkg::OP_RUN: begin
            ovalid_nxt = 1'b1;
            okind_nxt  = 1'b0;
            ocell_nxt  = q_data.cell_code;
            ocol_nxt   = col_r;
            orow_nxt   = row_r;
            odone_nxt  = 1'b0;
            olast_nxt  = q_data.last && (q_data.count == pcrl_pkg::CNT_W'(1));
            cnt_nxt    = q_data.count - 1'b1;
            active_nxt = (q_data.count != pcrl_pkg::CNT_W'(1));
            cell_nxt   = q_data.cell_code;
            clast_nxt  = q_data.last;
            col_nxt    = col_adv;
            row_nxt    = row_adv;
          end
          pcrl_pkg::OP_POS: begin
            ovalid_nxt = 1'b1;
            okind_nxt  = 1'b1;
            ocell_nxt  = pcrl_pkg::CELL_EMPTY;
            ocol_nxt   = q_data.col;
            orow_nxt   = q_data.row;
            odone_nxt  = 1'b1;
            olast_nxt  = 1'b1;
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Control and position state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovalid_r <= 1'b0;
      active_r <= 1'b0;
      width_r  <= '0;
      col_r    <= '0;
      row_r    <= '0;
    end else begin
      ovalid_r <= ovalid_nxt;
      active_r <= active_nxt;
      width_r  <= width_nxt;
      col_r    <= col_nxt;
      row_r    <= row_nxt;
    end
  end

  // Output and run payload.
  always_ff @(posedge clk) begin
    okind_r <= okind_nxt;
    ocell_r <= ocell_nxt;
    ocol_r  <= ocol_nxt;
    orow_r  <= orow_nxt;
    odone_r <= odone_nxt;
    olast_r <= olast_nxt;
    cnt_r   <= cnt_nxt;
    cell_r  <= cell_nxt;
    clast_r <= clast_nxt;
  end

  a_active_count: assert property (@(posedge clk) disable iff (!rst_n)
    active_r |-> (cnt_r != '0))
    else $error("run expansion active with no cells left");

  a_pos_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (ovalid_r && okind_r) |-> (odone_r && olast_r))
    else $error("position result without done and last");

endmodule

`default_nettype wire

FILE: rtl/core/prefix_code_run_length_map_decoder_top.sv
// Packed grid-map decoder, top level. Header and epilog bytes are handled when taken; a
// cell byte has an accepting step, a walk over its stream bits in the parser (cut short
// when the grid ends inside the byte) and a closing step. The expander sends one result
// per cycle while the output is not stalled. A run is queued when the next run of the
// byte ends or at its closing step; its first cell goes through the queue and the output
// register. Synchronous active-low reset empties the queue and waits for a width byte.
`default_nettype none

module prefix_code_run_length_map_decoder_top #(
  parameter int MAX_COLS = 40,
  parameter int MAX_ROWS = 25
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  pcrl_in_if.sink     in_chan,
  pcrl_out_if.source  out_chan
);

  pcrl_pkg::cmd_t push_data;
  pcrl_pkg::cmd_t pop_data;
  logic           push;
  logic           pop;
  logic           full;
  logic           empty;

  // Byte parser.
  pcrl_front #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .q_full  (full),
    .q_push  (push),
    .q_data  (push_data)
  );

  // Command queue.
  pcrl_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (empty)
  );

  // Cell expander.
  pcrl_back #(
    .MAX_COLS (MAX_COLS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_empty  (empty),
    .q_pop    (pop),
    .q_data   (pop_data),
    .out_chan (out_chan)
  );

endmodule

`default_nettype wire
